FILE: sv/dmm_pkg.sv
package dmm_pkg;

   localparam int CFG_W  = 4;
   localparam int DATA_W = 16;
   localparam int PROD_W = 32;
   localparam int SUM_W  = 35;
   localparam int POS_W  = 3;
   localparam int KIND_W = 2;
   localparam int IDX_W  = 6;
   localparam int ADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_WRITE_A = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_B = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START   = 2'd2;

   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_COLS_B    = 2'd1;
   localparam logic [1:0] REG_INNER_LEN = 2'd2;

   localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

FILE: sv/dense_matrix_multiply_top.sv
// Fixed-point matrix multiply C = A * B. A request of kind write-A or write-B
// stores one signed Q8.8 element at a row-major index (indices of
// MAX_DIM*MAX_DIM and above are dropped). A start request streams
// out rows_a*cols_b elements of C in row-major order as signed Q19.16 sums,
// the final one flagged by rsp_last. One multiplier is shared by all products:
// each element issues one store read per product, then passes the read,
// multiply and accumulate registers before the output load, which waits
// while the previous element is held by rsp_stall; request stall stays high
// for the whole run. Dimension registers at 0 act as 1 and above MAX_DIM act as
// MAX_DIM; write them only while the block is idle.
// Elements must be written before a run reads them.
module dense_matrix_multiply_top #(
   parameter int MAX_DIM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dmm_pkg::KIND_W-1:0]          req_kind,
   input  logic [dmm_pkg::IDX_W-1:0]           req_index,
   input  logic signed [dmm_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dmm_pkg::POS_W-1:0]           rsp_row,
   output logic [dmm_pkg::POS_W-1:0]           rsp_col,
   output logic signed [dmm_pkg::SUM_W-1:0]    rsp_product_sum,
   output logic                                rsp_last,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dmm_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [dmm_pkg::PDATA_W-1:0]         csr_pwdata,
   output logic [dmm_pkg::PDATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);
   import dmm_pkg::*;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(STORE_DEPTH);
   localparam int DW = $clog2(MAX_DIM);
   localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(STORE_DEPTH);

   logic [CFG_W-1:0] rows_a_ff, rows_a_in;
   logic [CFG_W-1:0] cols_b_ff, cols_b_in;
   logic [CFG_W-1:0] inner_len_ff, inner_len_in;
   logic             cfg_wr;
   logic [1:0]       reg_sel;

   logic             req_take, busy, start, idx_ok, wr_a, wr_b;
   logic [AW-1:0]    a_addr, b_addr;
   logic [DATA_W-1:0] a_data, b_data;
   mac_ctl_type      rd_ctl;
   logic             mac_done;
   logic signed [SUM_W-1:0] mac_acc;

   assign reg_sel    = csr_paddr[3:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      rows_a_in    = rows_a_ff;
      cols_b_in    = cols_b_ff;
      inner_len_in = inner_len_ff;
      if (cfg_wr) begin
         unique case (reg_sel)
            REG_ROWS_A:    rows_a_in    = csr_pwdata[CFG_W-1:0];
            REG_COLS_B:    cols_b_in    = csr_pwdata[CFG_W-1:0];
            REG_INNER_LEN: inner_len_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
         inner_len_ff <= DIM_RESET;
      end else begin
         rows_a_ff    <= rows_a_in;
         cols_b_ff    <= cols_b_in;
         inner_len_ff <= inner_len_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ROWS_A:    csr_prdata = PDATA_W'(rows_a_ff);
         REG_COLS_B:    csr_prdata = PDATA_W'(cols_b_ff);
         REG_INNER_LEN: csr_prdata = PDATA_W'(inner_len_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_stall = busy;
   assign req_take  = req_valid && !busy;
   assign idx_ok    = {1'b0, req_index} < DEPTH_LIM;
   assign wr_a      = req_take && (req_kind == KIND_WRITE_A) && idx_ok;
   assign wr_b      = req_take && (req_kind == KIND_WRITE_B) && idx_ok;
   assign start     = req_take && (req_kind == KIND_START);

   dmm_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (req_index[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   dmm_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (req_index[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   dmm_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (rd_ctl),
      .a_val ($signed(a_data)),
      .b_val ($signed(b_data)),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   dmm_seq #(.MAX_DIM(MAX_DIM), .AW(AW), .DW(DW)) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .rows_a          (rows_a_ff),
      .cols_b          (cols_b_ff),
      .inner_len       (inner_len_ff),
      .mac_done        (mac_done),
      .mac_acc         (mac_acc),
      .rsp_stall       (rsp_stall),
      .busy            (busy),
      .a_addr          (a_addr),
      .b_addr          (b_addr),
      .rd_ctl          (rd_ctl),
      .rsp_valid       (rsp_valid),
      .rsp_row         (rsp_row),
      .rsp_col         (rsp_col),
      .rsp_product_sum (rsp_product_sum),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: sv/dmm_store.sv
module dmm_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [dmm_pkg::DATA_W-1:0]  wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [dmm_pkg::DATA_W-1:0]  rd_data
);
   import dmm_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/dmm_mac.sv
module dmm_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  dmm_pkg::mac_ctl_type              ctl,
   input  logic signed [dmm_pkg::DATA_W-1:0] a_val,
   input  logic signed [dmm_pkg::DATA_W-1:0] b_val,
   output logic                              done,
   output logic signed [dmm_pkg::SUM_W-1:0]  acc
);
   import dmm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   mac_ctl_type              prod_ctl_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  acc_in;
   logic signed [SUM_W-1:0]  prod_ext;
   logic                     done_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a_val * b_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         prod_ctl_ff <= ctl;
         done_ff     <= prod_ctl_ff.valid && prod_ctl_ff.last;
      end
   end

   always_comb begin
      prod_ext = SUM_W'(prod_ff);
      acc_in   = acc_ff;
      if (prod_ctl_ff.valid) begin
         acc_in = prod_ctl_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

FILE: sv/dmm_seq.sv
module dmm_seq #(
   parameter int MAX_DIM = 8,
   parameter int AW      = 6,
   parameter int DW      = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dmm_pkg::CFG_W-1:0]         rows_a,
   input  logic [dmm_pkg::CFG_W-1:0]         cols_b,
   input  logic [dmm_pkg::CFG_W-1:0]         inner_len,
   input  logic                              mac_done,
   input  logic signed [dmm_pkg::SUM_W-1:0]  mac_acc,
   input  logic                              rsp_stall,
   output logic                              busy,
   output logic [AW-1:0]                     a_addr,
   output logic [AW-1:0]                     b_addr,
   output dmm_pkg::mac_ctl_type              rd_ctl,
   output logic                              rsp_valid,
   output logic [dmm_pkg::POS_W-1:0]         rsp_row,
   output logic [dmm_pkg::POS_W-1:0]         rsp_col,
   output logic signed [dmm_pkg::SUM_W-1:0]  rsp_product_sum,
   output logic                              rsp_last
);
   import dmm_pkg::*;

   function automatic logic [DW-1:0] dim_m1(input logic [CFG_W-1:0] r);
      logic [DW-1:0] res;
      if (r == '0) begin
         res = '0;
      end else if (r > CFG_W'(MAX_DIM)) begin
         res = DW'(MAX_DIM - 1);
      end else begin
         res = DW'(r - CFG_W'(1));
      end
      return res;
   endfunction

   seq_state_type state_ff, state_in;
   logic [DW-1:0] y_ff, y_in, x_ff, x_in, k_ff, k_in;
   logic [AW-1:0] a_base_ff, a_base_in, a_addr_ff, a_addr_in, b_addr_ff, b_addr_in;
   mac_ctl_type   rd_ctl_in, rd_ctl_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic                    rsp_last_ff;
   logic          load_out;
   logic [DW-1:0] ny_m1, nx_m1, nk_m1;
   logic [AW-1:0] nx_aw, nk_aw;
   logic          final_elem;

   assign ny_m1 = dim_m1(rows_a);
   assign nx_m1 = dim_m1(cols_b);
   assign nk_m1 = dim_m1(inner_len);
   assign nx_aw = AW'(nx_m1) + AW'(1);
   assign nk_aw = AW'(nk_m1) + AW'(1);
   assign final_elem = (y_ff == ny_m1) && (x_ff == nx_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ctl_ff    <= rd_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff      <= y_in;
      x_ff      <= x_in;
      k_ff      <= k_in;
      a_base_ff <= a_base_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      if (load_out) begin
         rsp_row_ff  <= POS_W'(y_ff);
         rsp_col_ff  <= POS_W'(x_ff);
         rsp_sum_ff  <= mac_acc;
         rsp_last_ff <= final_elem;
      end
   end

   always_comb begin
      state_in  = state_ff;
      y_in      = y_ff;
      x_in      = x_ff;
      k_in      = k_ff;
      a_base_in = a_base_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      rd_ctl_in = '0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               y_in      = '0;
               x_in      = '0;
               k_in      = '0;
               a_base_in = '0;
               a_addr_in = '0;
               b_addr_in = '0;
               state_in  = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            rd_ctl_in.valid = 1'b1;
            rd_ctl_in.first = (k_ff == '0);
            rd_ctl_in.last  = (k_ff == nk_m1);
            a_addr_in = a_addr_ff + AW'(1);
            b_addr_in = b_addr_ff + nx_aw;
            k_in      = k_ff + DW'(1);
            if (k_ff == nk_m1) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               if (final_elem) begin
                  state_in = ST_IDLE;
               end else if (x_ff == nx_m1) begin
                  x_in      = '0;
                  y_in      = y_ff + DW'(1);
                  a_base_in = a_base_ff + nk_aw;
                  a_addr_in = a_base_ff + nk_aw;
                  b_addr_in = '0;
                  state_in  = ST_ISSUE;
               end else begin
                  x_in      = x_ff + DW'(1);
                  a_addr_in = a_base_ff;
                  b_addr_in = AW'(x_ff) + AW'(1);
                  state_in  = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   assign busy            = (state_ff != ST_IDLE);
   assign a_addr          = a_addr_ff;
   assign b_addr          = b_addr_ff;
   assign rd_ctl          = rd_ctl_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_col         = rsp_col_ff;
   assign rsp_product_sum = rsp_sum_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: sv/dmm_check.sv
module dmm_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [dmm_pkg::KIND_W-1:0]          req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [dmm_pkg::POS_W-1:0]           rsp_row,
   input logic [dmm_pkg::POS_W-1:0]           rsp_col,
   input logic signed [dmm_pkg::SUM_W-1:0]    rsp_product_sum,
   input logic                                rsp_last
);
   import dmm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col)
         && $stable(rsp_product_sum) && $stable(rsp_last))
      else $error("stalled response changed");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_START) |=> req_stall)
      else $error("start request did not make the block busy");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken in the middle of a run");

endmodule

bind dense_matrix_multiply_top dmm_check u_dmm_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_row         (rsp_row),
   .rsp_col         (rsp_col),
   .rsp_product_sum (rsp_product_sum),
   .rsp_last        (rsp_last)
);

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmm_pkg::*;

   localparam int MAX_DIM = 8;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
   localparam int SETTLE_CYCLES = 24;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] value;
      bit                       hold;
   } load_req_type;

   typedef struct {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } c_elem_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [KIND_W-1:0]         req_kind = '0;
   logic [IDX_W-1:0]          req_index = '0;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [POS_W-1:0]          rsp_row;
   logic [POS_W-1:0]          rsp_col;
   logic signed [SUM_W-1:0]   rsp_product_sum;
   logic                      rsp_last;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]         csr_paddr = '0;
   logic [PDATA_W-1:0]        csr_pwdata = '0;
   logic [PDATA_W-1:0]        csr_prdata;
   logic                      csr_pready;

   dense_matrix_multiply_top #(.MAX_DIM(MAX_DIM)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_index      (req_index),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_product_sum(rsp_product_sum),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   load_req_type pending_requests[$];
   c_elem_type   expected_elems[$];
   int        mismatch_count = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   bit        req_taken = 1'b0;

   // shadow of the block: registers and both stores
   logic [CFG_W-1:0]         rows_reg = DIM_RESET;
   logic [CFG_W-1:0]         cols_reg = DIM_RESET;
   logic [CFG_W-1:0]         inner_reg = DIM_RESET;
   logic signed [DATA_W-1:0] a_store [STORE_DEPTH];
   logic signed [DATA_W-1:0] b_store [STORE_DEPTH];

   // entries already queued for writing; a start is only queued when it reads these alone
   bit a_seen [STORE_DEPTH];
   bit b_seen [STORE_DEPTH];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_dim(logic [CFG_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_DIM) return MAX_DIM;
      return int'(r);
   endfunction

   function automatic void compute_product_elems();
      int ny, nx, nk;
      longint acc;
      c_elem_type e;
      ny = eff_dim(rows_reg);
      nx = eff_dim(cols_reg);
      nk = eff_dim(inner_reg);
      for (int y = 0; y < ny; y++) begin
         for (int x = 0; x < nx; x++) begin
            acc = 0;
            for (int i = 0; i < nk; i++)
               acc += longint'(a_store[y * nk + i]) * longint'(b_store[i * nx + x]);
            e.row  = POS_W'(y);
            e.col  = POS_W'(x);
            e.sum  = acc[SUM_W-1:0];
            e.last = (y == ny - 1) && (x == nx - 1);
            expected_elems = {expected_elems, e};
         end
      end
   endfunction

   // request side: predict on acceptance; result side: compare with oldest expectation
   always @(posedge clock) begin
      c_elem_type e;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            case (req_kind)
               KIND_WRITE_A: a_store[req_index] = req_value;
               KIND_WRITE_B: b_store[req_index] = req_value;
               KIND_START:   compute_product_elems();
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_elems.size() == 0) begin
               $display("%0t: unexpected result row %0d col %0d sum %0d last %0b", $time,
                        rsp_row, rsp_col, rsp_product_sum, rsp_last);
               mismatch_count++;
            end else begin
               e = expected_elems.pop_front();
               if ({rsp_row, rsp_col, rsp_product_sum, rsp_last} !==
                   {e.row, e.col, e.sum, e.last}) begin
                  $display("%0t: mismatch exp row %0d col %0d sum %0d last %0b,", $time,
                           e.row, e.col, e.sum, e.last,
                           " got row %0d col %0d sum %0d last %0b",
                           rsp_row, rsp_col, rsp_product_sum, rsp_last);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      load_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() > 0 &&
             !(pending_requests[0].hold && expected_elems.size() > 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            r = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_kind  <= r.kind;
            req_index <= r.index;
            req_value <= r.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void queue_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                         logic signed [DATA_W-1:0] val, bit hold);
      load_req_type r;
      r.kind  = kind;
      r.index = idx;
      r.value = val;
      r.hold  = hold;
      pending_requests = {pending_requests, r};
      if (kind == KIND_WRITE_A) a_seen[idx] = 1'b1;
      else if (kind == KIND_WRITE_B) b_seen[idx] = 1'b1;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_q88();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] rand_dim();
      case ($urandom_range(9))
         0: return '0;
         1: return CFG_W'($urandom_range(9, 15));
         2: return CFG_W'($urandom_range(4, 8));
         default: return CFG_W'($urandom_range(1, 3));
      endcase
   endfunction

   // one load-then-start sequence, or a burst of noise; returns requests queued
   function automatic int queue_sequence();
      int ny, nx, nk;
      int n = 0;
      logic [KIND_W-1:0] k;
      ny = eff_dim(rows_reg);
      nx = eff_dim(cols_reg);
      nk = eff_dim(inner_reg);
      if ($urandom_range(6) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(2))
               0: k = KIND_IGNORED;
               1: k = KIND_WRITE_A;
               default: k = KIND_WRITE_B;
            endcase
            queue_request(k, IDX_W'($urandom), rand_q88(), 1'b0);
            n++;
         end
         return n;
      end
      for (int j = 0; j < ny * nk; j++)
         if (!a_seen[j] || $urandom_range(3) != 0) begin
            queue_request(KIND_WRITE_A, IDX_W'(j), rand_q88(), 1'b0);
            n++;
         end
      for (int j = 0; j < nk * nx; j++)
         if (!b_seen[j] || $urandom_range(3) != 0) begin
            queue_request(KIND_WRITE_B, IDX_W'(j), rand_q88(), 1'b0);
            n++;
         end
      queue_request(KIND_START, IDX_W'($urandom), DATA_W'($urandom),
                    $urandom_range(3) == 0);
      return n + 1;
   endfunction

   task automatic csr_check(logic [1:0] reg_id, logic [CFG_W-1:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_id, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[CFG_W-1:0] !== want) begin
         $display("%0t: register %0d readback exp %0d got %0d", $time, reg_id, want,
                  csr_prdata[CFG_W-1:0]);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(logic [1:0] reg_id, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_id, 2'b00};
      csr_pwdata  <= ($urandom & 32'hffff_fff0) | PDATA_W'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (reg_id)
         REG_ROWS_A: rows_reg = val;
         REG_COLS_B: cols_reg = val;
         default:    inner_reg = val;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_check(reg_id, val);
   endtask

   task automatic set_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c, logic [CFG_W-1:0] i);
      csr_write(REG_ROWS_A, r);
      csr_write(REG_COLS_B, c);
      csr_write(REG_INNER_LEN, i);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_elems.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int count;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check(REG_ROWS_A, DIM_RESET);
      csr_check(REG_COLS_B, DIM_RESET);
      csr_check(REG_INNER_LEN, DIM_RESET);

      // 1x1x1 via zero registers: extreme products, ignored kind, top index
      set_dims('0, '0, '0);
      queue_request(KIND_WRITE_A, '0, 16'sh7fff, 1'b0);
      queue_request(KIND_WRITE_B, '0, 16'sh7fff, 1'b0);
      queue_request(KIND_START, '0, '0, 1'b0);
      queue_request(KIND_WRITE_A, '0, 16'sh8000, 1'b0);
      queue_request(KIND_WRITE_B, '0, 16'sh8000, 1'b0);
      queue_request(KIND_START, '1, 16'sh7fff, 1'b1);
      queue_request(KIND_WRITE_B, '0, 16'sh7fff, 1'b0);
      queue_request(KIND_START, 6'd21, 16'sh5555, 1'b0);
      queue_request(KIND_IGNORED, '1, 16'shffff, 1'b0);
      queue_request(KIND_WRITE_A, '1, 16'sh5555, 1'b0);
      queue_request(KIND_WRITE_B, '1, 16'shaaaa, 1'b0);
      queue_request(KIND_WRITE_A, '0, '0, 1'b0);
      queue_request(KIND_START, '1, 16'shffff, 1'b0);
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
         endcase
         if (ph == 5) begin
            // full size; largest positive sum, then most negative
            set_dims(4'd15, 4'd8, 4'd15);
            for (int j = 0; j < STORE_DEPTH; j++) begin
               queue_request(KIND_WRITE_A, IDX_W'(j), 16'sh8000, 1'b0);
               queue_request(KIND_WRITE_B, IDX_W'(j), 16'sh8000, 1'b0);
            end
            queue_request(KIND_START, '0, '0, 1'b0);
            for (int j = 0; j < STORE_DEPTH; j++)
               queue_request(KIND_WRITE_B, IDX_W'(j), 16'sh7fff, 1'b0);
            queue_request(KIND_START, '1, '1, 1'b0);
         end else begin
            set_dims(rand_dim(), rand_dim(), rand_dim());
            count = 0;
            while (count < 10)
               count += queue_sequence();
         end
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
